// ===== src/xrng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrng_pkg
// Shared constants, codes and controller/datapath types for the xorshift128
// random generator.
// ----------------------------------------------------------------------------
package xrng_pkg;

  // request modes
  localparam logic [1:0] MODE_SEED   = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_RANGE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SpanW  = WordW + 1;
  localparam int unsigned NWords = 4;
  localparam int unsigned IdxW   = $clog2(NWords);

  localparam logic [WordW-1:0] SeedMult  = 32'd1812433253;
  localparam logic [WordW-1:0] ResetW0   = 32'd123456789;
  localparam logic [WordW-1:0] ResetW1   = 32'd362436069;
  localparam logic [WordW-1:0] ResetW2   = 32'd521288629;
  localparam logic [WordW-1:0] ResetW3   = 32'd88675123;

  localparam int unsigned ShiftA     = 11;
  localparam int unsigned ShiftB     = 8;
  localparam int unsigned ShiftC     = 19;
  localparam int unsigned SeedShift  = 30;

  localparam logic [IdxW-1:0] SeedLast = IdxW'(NWords - 1);

  typedef enum logic [1:0] {
    OUT_RAW,
    OUT_RANGE,
    OUT_EMPTY
  } out_sel_e;

  typedef struct packed {
    logic            load;
    logic            seed_step;
    logic [IdxW-1:0] seed_idx;
    logic            advance;
    logic            mult;
    logic            out_load;
    out_sel_e        out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] in_mode;
    logic       in_empty;
    logic [1:0] mode;
    logic       empty;
  } dp_status_t;

endpackage

// ===== src/xrng_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrng request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface xrng_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [31:0]        seed;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  modport source (output valid, mode, seed, range_min, range_max, input ready);
  modport sink   (input valid, mode, seed, range_min, range_max, output ready);
endinterface

interface xrng_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        raw_word;
  logic signed [31:0] ranged_value;

  modport source (output valid, raw_word, ranged_value, input ready);
  modport sink   (input valid, raw_word, ranged_value, output ready);
endinterface

// ===== src/xrng_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrng_ctrl
// Sequencer for reseed, draw and ranged draw; owns the result valid flag.
// ----------------------------------------------------------------------------
module xrng_ctrl import xrng_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.out_sel = OUT_RAW;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (status_i.in_mode)
            MODE_SEED: begin
              state_d = ST_SEED;
              cnt_d   = '0;
            end
            MODE_RAW:   state_d = ST_ADV;
            MODE_RANGE: state_d = status_i.in_empty ? ST_EMIT : ST_ADV;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        cmd_o.seed_idx  = cnt_q;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SeedLast) state_d = ST_IDLE;
      end
      ST_ADV: begin
        if (status_i.mode == MODE_RAW) begin
          // raw draw goes straight to the result register
          if (slot_free) begin
            cmd_o.advance  = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = OUT_RAW;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = status_i.empty ? OUT_EMPTY : OUT_RANGE;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/xrng_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrng_datapath
// Generator words, seed recurrence, range multiplier and result register.
// ----------------------------------------------------------------------------
module xrng_datapath import xrng_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              req_mode_i,
  input  logic [WordW-1:0]        req_seed_i,
  input  logic signed [WordW-1:0] req_min_i,
  input  logic signed [WordW-1:0] req_max_i,
  input  ctrl_cmd_t               cmd_i,
  output dp_status_t              status_o,
  output logic [WordW-1:0]        raw_word_o,
  output logic signed [WordW-1:0] ranged_value_o
);

  logic [WordW-1:0]        words_q [NWords];
  logic [WordW-1:0]        p_q;
  logic [WordW-1:0]        w_q;
  logic [WordW-1:0]        prod_hi_q;
  logic [SpanW-1:0]        span_q, span_d;
  logic signed [WordW-1:0] lo_q;
  logic [1:0]              mode_q;
  logic                    empty_q, in_empty;
  logic [WordW-1:0]        raw_q;
  logic signed [WordW-1:0] ranged_q;

  logic [WordW-1:0]        t_word, adv_word, mix, seed_word, off;
  logic [2*WordW-1:0]      prod;

  assign in_empty = (req_min_i >= req_max_i);
  assign span_d   = {req_max_i[WordW-1], req_max_i} - {req_min_i[WordW-1], req_min_i}
                    + SpanW'(1);

  assign t_word   = words_q[0] ^ (words_q[0] << ShiftA);
  assign adv_word = (words_q[3] ^ (words_q[3] >> ShiftC)) ^ (t_word ^ (t_word >> ShiftB));

  assign mix       = p_q ^ (p_q >> SeedShift);
  assign seed_word = SeedMult * mix + WordW'(cmd_i.seed_idx) + WordW'(1);

  assign prod = {{WordW{1'b0}}, w_q} * {{WordW{1'b0}}, span_q[WordW-1:0]};
  // a full 2^32 span maps the word onto itself
  assign off  = span_q[SpanW-1] ? w_q : prod_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q[0] <= ResetW0;
      words_q[1] <= ResetW1;
      words_q[2] <= ResetW2;
      words_q[3] <= ResetW3;
    end else if (cmd_i.seed_step) begin
      words_q[cmd_i.seed_idx] <= seed_word;
    end else if (cmd_i.advance) begin
      words_q[0] <= words_q[1];
      words_q[1] <= words_q[2];
      words_q[2] <= words_q[3];
      words_q[3] <= adv_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= req_mode_i;
      empty_q <= in_empty;
      lo_q    <= req_min_i;
      span_q  <= span_d;
      p_q     <= req_seed_i;
    end else if (cmd_i.seed_step) begin
      p_q <= seed_word;
    end
    if (cmd_i.advance) w_q <= adv_word;
    if (cmd_i.mult) prod_hi_q <= prod[2*WordW-1:WordW];
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_sel)
        OUT_RAW: begin
          raw_q    <= adv_word;
          ranged_q <= '0;
        end
        OUT_RANGE: begin
          raw_q    <= w_q;
          ranged_q <= lo_q + $signed(off);
        end
        OUT_EMPTY: begin
          raw_q    <= '0;
          ranged_q <= lo_q;
        end
        default: begin
          raw_q    <= '0;
          ranged_q <= '0;
        end
      endcase
    end
  end

  assign status_o.in_mode  = req_mode_i;
  assign status_o.in_empty = in_empty;
  assign status_o.mode     = mode_q;
  assign status_o.empty    = empty_q;

  assign raw_word_o     = raw_q;
  assign ranged_value_o = ranged_q;

endmodule

// ===== src/xorshift128_random_generator_core.sv =====
`timescale 1ns / 1ps
// raw draw: the shift-xor step writes the result; no new request is taken before that
// ranged draw: the advance, the 32x32 range multiply and the offset add, in that order
// empty range (min >= max): no advance; reseed: one multiply per word
// an unused mode is dropped in the accept cycle
// reset loads the four standard xorshift128 words; no result is pending after reset
// ----------------------------------------------------------------------------
// xorshift128_random_generator_core
// xorshift128 generator with seeded reload and exact mapping into a range.
// ----------------------------------------------------------------------------
module xorshift128_random_generator_core import xrng_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  xrng_req_if.sink  req_i,
  xrng_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  xrng_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xrng_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mode_i     (req_i.mode),
    .req_seed_i     (req_i.seed),
    .req_min_i      (req_i.range_min),
    .req_max_i      (req_i.range_max),
    .cmd_i          (cmd),
    .status_o       (status),
    .raw_word_o     (rsp_o.raw_word),
    .ranged_value_o (rsp_o.ranged_value)
  );

endmodule

// ===== src/xrng_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrng_checker
// Port-level checks on the generator's request and result channels.
// ----------------------------------------------------------------------------
module xrng_checker import xrng_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_mode_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_raw_i,
  input logic [31:0] rsp_ranged_i
);

  // result beat holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_raw_i) && $stable(rsp_ranged_i))
    else $error("result payload changed while stalled");

  // any real request leaves the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_mode_i != MODE_UNUSED) |=> !req_ready_i)
    else $error("request taken again without processing");

  // a new result only appears after the block was busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result appeared without a request in flight");

endmodule

bind xorshift128_random_generator_core xrng_checker u_xrng_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_mode_i   (req_i.mode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_raw_i    (rsp_o.raw_word),
  .rsp_ranged_i (rsp_o.ranged_value)
);

// ===== sim/xorshift128_random_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift128_random_generator_core_tb
// Drives reseed, raw draw, ranged draw and unused-mode requests through the
// request channel with random gaps and back-pressure on the result channel.
// A directed table covers reset state, range extremes and empty ranges. It is
// followed by about 1100 random requests. Every result beat is checked field by
// field against an in-order queue filled by a behavioral generator model.
// ----------------------------------------------------------------------------
module xorshift128_random_generator_core_tb;
  import xrng_pkg::*;

  typedef struct packed {
    logic [31:0]        raw_word;
    logic signed [31:0] ranged_value;
  } draw_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        seed;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic               fixed;
    draw_t              draw;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  xrng_req_if req_if ();
  xrng_rsp_if rsp_if ();

  xorshift128_random_generator_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  logic [31:0] gen_words [NWords];
  draw_t       pending_draws [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  function automatic logic [31:0] seed_mix(logic [31:0] prev, logic [31:0] add);
    return SeedMult * (prev ^ (prev >> SeedShift)) + add;
  endfunction

  function automatic logic [31:0] step_generator();
    logic [31:0] t;
    logic [31:0] last;
    t    = gen_words[0] ^ (gen_words[0] << ShiftA);
    last = gen_words[3];
    gen_words[0] = gen_words[1];
    gen_words[1] = gen_words[2];
    gen_words[2] = last;
    gen_words[3] = (last ^ (last >> ShiftC)) ^ (t ^ (t >> ShiftB));
    return gen_words[3];
  endfunction

  // updates the generator copy and tells whether the request yields a result
  function automatic bit predict_draw(logic [1:0] mode, logic [31:0] seed,
                                      logic signed [31:0] lo, logic signed [31:0] hi,
                                      output draw_t draw);
    longint      span;
    logic [63:0] prod;
    logic [31:0] word;
    draw = '0;
    case (mode)
      MODE_SEED: begin
        gen_words[0] = seed_mix(seed, 32'd1);
        gen_words[1] = seed_mix(gen_words[0], 32'd2);
        gen_words[2] = seed_mix(gen_words[1], 32'd3);
        gen_words[3] = seed_mix(gen_words[2], 32'd4);
        return 1'b0;
      end
      MODE_RAW: begin
        draw.raw_word = step_generator();
        return 1'b1;
      end
      MODE_RANGE: begin
        if (lo >= hi) begin
          draw.ranged_value = lo;
          return 1'b1;
        end
        span = longint'(hi) - longint'(lo) + 1;
        word = step_generator();
        prod = {32'd0, word} * 64'(span);
        draw.raw_word     = word;
        draw.ranged_value = lo + prod[63:32];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic signed [31:0] pick_bound(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($urandom_range(0, 200)) - 32'sd100;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] mode, logic [31:0] seed,
                                       logic signed [31:0] lo, logic signed [31:0] hi,
                                       logic fixed, logic [31:0] raw,
                                       logic signed [31:0] ranged);
    stim_row_t r;
    r.mode = mode;
    r.seed = seed;
    r.range_min = lo;
    r.range_max = hi;
    r.fixed = fixed;
    r.draw.raw_word = raw;
    r.draw.ranged_value = ranged;
    return r;
  endfunction

  // one request beat, then the model update; a typed row overrides the expectation
  task automatic issue_request(stim_row_t r);
    int    gap;
    draw_t draw;
    bit    has_draw;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= r.mode;
    req_if.seed      <= r.seed;
    req_if.range_min <= r.range_min;
    req_if.range_max <= r.range_max;
    do @(posedge clk_i); while (!req_if.ready);
    has_draw = predict_draw(r.mode, r.seed, r.range_min, r.range_max, draw);
    if (r.fixed) draw = r.draw;
    if (has_draw) pending_draws.push_back(draw);
  endtask

  // result side: random stall before each beat
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_draws.size() == 0) begin
        $error("result beat with nothing expected: raw_word %0d ranged_value %0d",
               rsp_if.raw_word, rsp_if.ranged_value);
        mismatch_count++;
      end else begin
        want = pending_draws.pop_front();
        if (rsp_if.raw_word !== want.raw_word) begin
          $error("raw_word: expected %0d, got %0d", want.raw_word, rsp_if.raw_word);
          mismatch_count++;
        end
        if (rsp_if.ranged_value !== want.ranged_value) begin
          $error("ranged_value: expected %0d, got %0d", want.ranged_value,
                 rsp_if.ranged_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #500000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t          directed_rows [$];
    stim_row_t          r;
    int                 done;
    int                 pick;
    logic signed [31:0] lo;
    logic signed [31:0] hi;

    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= MODE_SEED;
    req_if.seed      <= '0;
    req_if.range_min <= '0;
    req_if.range_max <= '0;
    gen_words[0] = ResetW0;
    gen_words[1] = ResetW1;
    gen_words[2] = ResetW2;
    gen_words[3] = ResetW3;

    // first draw after reset is the well-known first xorshift128 output
    directed_rows.push_back(mk_row(MODE_RAW, 0, 0, 0, 1, 32'd3701687786, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 5, 5, 1, 0, 5));
    // min above max and min equal max: no advance, value is min
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, 0,
                                   32'sh7fff_ffff));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 32'sh8000_0000, 32'sh8000_0000, 1, 0,
                                   32'sh8000_0000));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 0, -1, 1, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, -1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 32'sh7fff_fffe, 32'sh7fff_ffff, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_UNUSED, 32'hffff_ffff, -1, -1, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RAW, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_SEED, 32'd0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RAW, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, -10, 10, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_SEED, 32'hffff_ffff, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RAW, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 32'hffff_ffff, 32'sh8000_0000,
                                   32'sh7fff_ffff, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_SEED, 32'd1, -1, -1, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_SEED, 32'h8000_0000, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RAW, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MODE_RANGE, 0, 32'sh8000_0000, 32'sh8000_0001, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    done = 0;
    while (done < 1100) begin
      if (done % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      lo   = pick_bound($urandom_range(0, 3));
      hi   = lo;
      case ($urandom_range(0, 3))
        0: hi = lo + 32'($urandom_range(0, 15));
        1: hi = pick_bound($urandom_range(0, 3));
        default: hi = $urandom;
      endcase
      r = mk_row(MODE_RAW, $urandom, lo, hi, 0, 0, 0);
      if (pick < 8) r.mode = MODE_SEED;
      else if (pick < 50) r.mode = MODE_RAW;
      else if (pick < 95) r.mode = MODE_RANGE;
      else r.mode = MODE_UNUSED;
      issue_request(r);
      if (r.mode != MODE_UNUSED) done++;
    end
    req_if.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/xrng_pkg.sv
src/xrng_stream_if.sv
src/xrng_ctrl.sv
src/xrng_datapath.sv
src/xorshift128_random_generator_core.sv
src/xrng_checker.sv
sim/xorshift128_random_generator_core_tb.sv
